FILE: src/ppr_pkg.sv
// Shared constants, codes and types for the pipe packet reassembly queue.
package ppr_pkg;

  localparam int QUEUE_DEPTH    = 8;
  localparam int ENTRY_BYTES    = 4096;
  localparam int ENDPOINT_BYTES = 512;
  localparam int HEADER_BYTES   = 4;

  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int OFF_W    = $clog2(ENTRY_BYTES);
  localparam int FILL_W   = OFF_W + 1;
  localparam int POS_W    = $clog2(HEADER_BYTES + ENTRY_BYTES + 1);
  localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_AW = SLOT_W + OFF_W;
  localparam int LEN_W    = 16;
  localparam int HDR_W    = HEADER_BYTES * 8;
  localparam int CMP_W    = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int META_W   = FILL_W + 1;

  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_READ     = 4'd0,
    ST_EMPTY    = 4'd1,
    ST_DROPPED  = 4'd2,
    ST_APPENDED = 4'd3,
    ST_CLOSED   = 4'd4,
    ST_SHORT    = 4'd5,
    ST_WRONG_ID = 4'd6,
    ST_FULL     = 4'd7,
    ST_ABNORMAL = 4'd8,
    ST_ERROR    = 4'd9,
    ST_CLEARED  = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    REJ_NONE     = 2'd0,
    REJ_WRONG_ID = 2'd1,
    REJ_FULL     = 2'd2,
    REJ_ABNORMAL = 2'd3
  } reject_t;

  // Per-entry bookkeeping held in the metadata memory.
  typedef struct packed {
    logic              bad;
    logic [FILL_W-1:0] fill;
  } meta_t;

endpackage

FILE: src/ppr_ram.sv
// Generic single-write, single-read memory with registered read data.
module ppr_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pipe_packet_reassembly_queue.sv
// Top level of the pipe packet reassembly queue: framing, ring control and read-out.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------------
//   input   | start & !busy       | in_kind, in_rx_byte, in_transfer_end, in_rx_error
//   result  | out_valid (1 cycle) | out_status, out_read_byte, out_entry_last,
//           |                     | out_truncated, out_queue_count
//   config  | cfg_we              | cfg_pipe_id
//
// Steps: a received byte takes a metadata memory read, then the update and byte
// write; a read request takes the metadata read, the store read and the byte out;
// a clear or an unused kind is done at acceptance. The registered read data of the
// two memories sets these steps; the result strobe follows the last step of its item.
// Reset (rst_n low, synchronous) empties the queue; the byte store itself is not
// cleared, since an entry is only read below its fill count.
// The receiver cannot stall: each result is shown for one cycle only.
module pipe_packet_reassembly_queue
  import ppr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_transfer_end,
  input  logic        in_rx_error,
  input  logic        cfg_we,
  input  logic [15:0] cfg_pipe_id,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic        out_entry_last,
  output logic        out_truncated,
  output logic [3:0]  out_queue_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_DATA
  } state_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  kind_t               kind_r;
  logic [7:0]          byte_r;
  logic                end_r;
  logic                err_r;

  logic [15:0]         pipe_id_r;
  logic [SLOT_W-1:0]   write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0]   read_slot_r, read_slot_nxt;
  logic [COUNT_W-1:0]  waiting_r, waiting_nxt;
  logic                abnormal_r, abnormal_nxt;
  logic [OFF_W-1:0]    read_offset_r, read_offset_nxt;
  logic [HDR_W-1:0]    hdr_r, hdr_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  reject_t             rej_r, rej_nxt;
  logic [QUEUE_DEPTH-1:0] vld_r, vld_nxt;   // metadata entry written since clear
  logic                meta_vld_r;          // valid bit of the entry now on rdata
  logic                last_r, last_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_trunc_r, out_trunc_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]   meta_raddr;
  meta_t               meta_rdata;
  logic                meta_we;
  logic [SLOT_W-1:0]   meta_waddr;
  meta_t               meta_wdata;

  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [STORE_AW-1:0] store_raddr;
  logic [7:0]          store_rdata;

  ppr_ram #(.WIDTH(META_W), .DEPTH(QUEUE_DEPTH)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  ppr_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH * ENTRY_BYTES)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (byte_r),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Look up the slot the incoming item will touch while it is being accepted.
  assign meta_raddr  = (kind_t'(in_kind) == KIND_READ) ? read_slot_r : write_slot_r;
  // Head entry byte at the current read offset; sampled in the metadata cycle.
  assign store_raddr = {read_slot_r, read_offset_r};

  assign busy = (state_r != S_IDLE);
  wire accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Datapath for the metadata cycle
  // ---------------------------------------------------------------------------
  logic [FILL_W-1:0] fill_old;
  logic              bad_old;
  logic [FILL_W-1:0] room;
  logic [HDR_W-1:0]  hdr_c;
  reject_t           rej_c;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  off;
  logic [POS_W-1:0]  got;
  logic [LEN_W-1:0]  len_cur;
  logic [LEN_W-1:0]  len_new;
  logic [CMP_W-1:0]  n_room;
  logic [CMP_W-1:0]  n_cnt;
  logic [FILL_W-1:0] fill_new;
  logic              trunc_c;
  logic              close_c;
  logic [FILL_W-1:0] rd_off_inc;

  // An entry never written since the last clear reads as empty and good.
  assign fill_old = meta_vld_r ? meta_rdata.fill : '0;
  assign bad_old  = meta_vld_r ? meta_rdata.bad  : 1'b0;
  assign room     = FILL_W'(ENTRY_BYTES) - fill_old;

  assign hdr_c   = (pos_r < POS_W'(HEADER_BYTES)) ? {byte_r, hdr_r[HDR_W-1:8]} : hdr_r;
  assign pos_inc = (pos_r < POS_W'(HEADER_BYTES + ENTRY_BYTES)) ? pos_r + 1'b1 : pos_r;
  assign off     = pos_r - POS_W'(HEADER_BYTES);
  assign got     = pos_inc - POS_W'(HEADER_BYTES);
  assign len_cur = hdr_r[HDR_W-1:HDR_W-LEN_W];
  assign len_new = hdr_c[HDR_W-1:HDR_W-LEN_W];

  // Decide acceptance on the last header byte: wrong id, then full, then abnormal.
  always_comb begin
    rej_c = rej_r;
    if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
      priority if (hdr_c[15:0] != pipe_id_r) begin
        rej_c = REJ_WRONG_ID;
      end else if (waiting_r >= COUNT_W'(QUEUE_DEPTH)) begin
        rej_c = REJ_FULL;
      end else if (abnormal_r) begin
        rej_c = REJ_ABNORMAL;
      end else begin
        rej_c = REJ_NONE;
      end
    end
  end

  // Bytes copied: least of header length, room and payload bytes received.
  assign trunc_c  = CMP_W'(len_new) > CMP_W'(room);
  assign n_room   = trunc_c ? CMP_W'(room) : CMP_W'(len_new);
  assign n_cnt    = (n_room > CMP_W'(got)) ? CMP_W'(got) : n_room;
  assign fill_new = fill_old + n_cnt[FILL_W-1:0];
  assign close_c  = (n_cnt == '0) || (n_cnt < CMP_W'(ENDPOINT_BYTES - HEADER_BYTES));

  assign rd_off_inc = {1'b0, read_offset_r} + 1'b1;

  // Append a payload byte while it lies within the header length and the room left.
  always_comb begin
    store_we    = 1'b0;
    store_waddr = {write_slot_r, fill_old[OFF_W-1:0] + off[OFF_W-1:0]};
    if (state_r == S_META && kind_r == KIND_RX && pos_r >= POS_W'(HEADER_BYTES) &&
        rej_r == REJ_NONE && CMP_W'(off) < CMP_W'(len_cur) &&
        CMP_W'(off) < CMP_W'(room)) begin
      store_we = 1'b1;
    end
  end

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic status_t reject_status(input reject_t r);
    status_t st;
    unique case (r)
      REJ_WRONG_ID: st = ST_WRONG_ID;
      REJ_FULL:     st = ST_FULL;
      REJ_ABNORMAL: st = ST_ABNORMAL;
      REJ_NONE:     st = ST_APPENDED;
    endcase
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt          = state_r;
    write_slot_nxt     = write_slot_r;
    read_slot_nxt      = read_slot_r;
    waiting_nxt        = waiting_r;
    abnormal_nxt       = abnormal_r;
    read_offset_nxt    = read_offset_r;
    hdr_nxt            = hdr_r;
    pos_nxt            = pos_r;
    rej_nxt            = rej_r;
    vld_nxt            = vld_r;
    last_nxt           = last_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_last_nxt       = 1'b0;
    out_trunc_nxt      = 1'b0;
    out_count_nxt      = out_count_r;
    out_byte_nxt       = 8'd0;
    meta_we            = 1'b0;
    meta_waddr         = write_slot_r;
    meta_wdata         = '{bad: 1'b0, fill: fill_new};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(in_kind))
            KIND_RX, KIND_READ: begin
              state_nxt = S_META;
            end
            KIND_CLEAR: begin
              // Empty the queue and abort any transfer in progress.
              write_slot_nxt  = '0;
              read_slot_nxt   = '0;
              waiting_nxt     = '0;
              abnormal_nxt    = 1'b0;
              read_offset_nxt = '0;
              hdr_nxt         = '0;
              pos_nxt         = '0;
              rej_nxt         = REJ_NONE;
              vld_nxt         = '0;
              out_valid_nxt   = 1'b1;
              out_status_nxt  = ST_CLEARED;
              out_count_nxt   = '0;
            end
            KIND_NONE: begin
            end
          endcase
        end
      end

      S_META: begin
        state_nxt = S_IDLE;
        if (kind_r == KIND_RX) begin
          hdr_nxt = hdr_c;
          pos_nxt = pos_inc;
          rej_nxt = rej_c;
          if (end_r) begin
            out_valid_nxt = 1'b1;
            priority if (pos_inc < POS_W'(HEADER_BYTES)) begin
              out_status_nxt = ST_SHORT;
            end else if (rej_c != REJ_NONE) begin
              out_status_nxt = reject_status(rej_c);
            end else if (err_r) begin
              // Mark the entry bad, queue it and hold off transfers until clear.
              meta_we                = 1'b1;
              meta_wdata             = '{bad: 1'b1, fill: fill_old};
              vld_nxt[write_slot_r]  = 1'b1;
              write_slot_nxt         = next_slot(write_slot_r);
              waiting_nxt            = waiting_r + 1'b1;
              abnormal_nxt           = 1'b1;
              out_status_nxt         = ST_ERROR;
            end else begin
              meta_we               = 1'b1;
              vld_nxt[write_slot_r] = 1'b1;
              out_trunc_nxt         = trunc_c;
              if (close_c) begin
                write_slot_nxt = next_slot(write_slot_r);
                waiting_nxt    = waiting_r + 1'b1;
                out_status_nxt = ST_CLOSED;
              end else begin
                out_status_nxt = ST_APPENDED;
              end
            end
            hdr_nxt       = '0;
            pos_nxt       = '0;
            rej_nxt       = REJ_NONE;
            out_count_nxt = waiting_nxt;
          end
        end else begin
          meta_waddr = read_slot_r;
          meta_wdata = '{bad: 1'b0, fill: '0};
          priority if (waiting_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_count_nxt  = waiting_r;
          end else if (bad_old || fill_old == '0) begin
            // Discard a bad or empty head entry.
            meta_we              = 1'b1;
            vld_nxt[read_slot_r] = 1'b1;
            read_slot_nxt        = next_slot(read_slot_r);
            waiting_nxt          = waiting_r - 1'b1;
            read_offset_nxt      = '0;
            out_valid_nxt        = 1'b1;
            out_status_nxt       = ST_DROPPED;
            out_count_nxt        = waiting_nxt;
          end else begin
            // Byte is on its way from the store; advance or retire the head.
            state_nxt = S_DATA;
            last_nxt  = (rd_off_inc >= fill_old);
            if (rd_off_inc >= fill_old) begin
              meta_we              = 1'b1;
              vld_nxt[read_slot_r] = 1'b1;
              read_slot_nxt        = next_slot(read_slot_r);
              waiting_nxt          = waiting_r - 1'b1;
              read_offset_nxt      = '0;
            end else begin
              read_offset_nxt = rd_off_inc[OFF_W-1:0];
            end
          end
        end
      end

      S_DATA: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_READ;
        out_last_nxt   = last_r;
        out_count_nxt  = waiting_r;
        // Capture the head byte before the store output follows the new read address.
        out_byte_nxt   = store_rdata;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State and registered outputs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      pipe_id_r        <= '0;
      write_slot_r     <= '0;
      read_slot_r      <= '0;
      waiting_r        <= '0;
      abnormal_r       <= 1'b0;
      read_offset_r    <= '0;
      hdr_r            <= '0;
      pos_r            <= '0;
      rej_r            <= REJ_NONE;
      vld_r            <= '0;
      last_r           <= 1'b0;
      out_valid_r      <= 1'b0;
      out_status_r     <= ST_READ;
      out_last_r       <= 1'b0;
      out_trunc_r      <= 1'b0;
      out_count_r      <= '0;
      out_byte_r       <= 8'd0;
    end else begin
      state_r          <= state_nxt;
      if (cfg_we) begin
        pipe_id_r <= cfg_pipe_id;
      end
      write_slot_r     <= write_slot_nxt;
      read_slot_r      <= read_slot_nxt;
      waiting_r        <= waiting_nxt;
      abnormal_r       <= abnormal_nxt;
      read_offset_r    <= read_offset_nxt;
      hdr_r            <= hdr_nxt;
      pos_r            <= pos_nxt;
      rej_r            <= rej_nxt;
      vld_r            <= vld_nxt;
      last_r           <= last_nxt;
      out_valid_r      <= out_valid_nxt;
      out_status_r     <= out_status_nxt;
      out_last_r       <= out_last_nxt;
      out_trunc_r      <= out_trunc_nxt;
      out_count_r      <= out_count_nxt;
      out_byte_r       <= out_byte_nxt;
    end
  end

  // Hold the accepted item and the valid bit of the slot being looked up.
  always_ff @(posedge clk) begin
    meta_vld_r <= vld_r[meta_raddr];
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      byte_r <= in_rx_byte;
      end_r  <= in_transfer_end;
      err_r  <= in_rx_error;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_byte   = out_byte_r;
  assign out_entry_last  = out_last_r;
  assign out_truncated   = out_trunc_r;
  assign out_queue_count = 4'(out_count_r);

endmodule

FILE: bench/pipe_packet_reassembly_queue_tb.sv
// Self-checking testbench for the pipe packet reassembly queue: directed, corner and random items.
module pipe_packet_reassembly_queue_tb
  import ppr_pkg::*;
();

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int STORE_BYTES   = QUEUE_DEPTH * ENTRY_BYTES;
  localparam int CLOSE_BELOW   = ENDPOINT_BYTES - HEADER_BYTES;
  localparam int RANDOM_ITEMS  = 64;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic [1:0]  in_kind         = KIND_RX;
  logic [7:0]  in_rx_byte      = 8'h00;
  logic        in_transfer_end = 1'b0;
  logic        in_rx_error     = 1'b0;
  logic        cfg_we          = 1'b0;
  logic [15:0] cfg_pipe_id     = 16'h0000;
  logic        out_valid;
  logic [3:0]  out_status;
  logic [7:0]  out_read_byte;
  logic        out_entry_last;
  logic        out_truncated;
  logic [3:0]  out_queue_count;

  pipe_packet_reassembly_queue uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .in_transfer_end(in_transfer_end),
    .in_rx_error    (in_rx_error),
    .cfg_we         (cfg_we),
    .cfg_pipe_id    (cfg_pipe_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_byte  (out_read_byte),
    .out_entry_last (out_entry_last),
    .out_truncated  (out_truncated),
    .out_queue_count(out_queue_count)
  );

  // One item as the sender presents it.
  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       err;
  } bus_item_t;

  // One result as the block should report it.
  typedef struct {
    status_t    status;
    logic [7:0] read_byte;
    logic       entry_last;
    logic       truncated;
    logic [3:0] queue_count;
  } queue_result_t;

  bus_item_t     pending_items[$];
  queue_result_t expected_results[$];
  queue_result_t oldest;

  int   cycle_count     = 0;
  int   items_taken     = 0;
  int   results_checked = 0;
  int   mismatches      = 0;
  int   pushed          = 0;
  logic item_taken      = 1'b0;
  logic status_seen [16];

  // Shadow copy of the queue, used to predict every result.
  logic [7:0]  q_store [STORE_BYTES];
  int          q_fill [QUEUE_DEPTH];
  logic        q_bad [QUEUE_DEPTH];
  int          q_wslot;
  int          q_rslot;
  int          q_waiting;
  int          q_roff;
  int          q_pos;
  logic        q_abnormal;
  logic [31:0] q_header;
  logic        q_rejected;
  status_t     q_reject_code;
  logic [15:0] q_pipe_id;

  // Sender pacing.
  int        gap_left   = 0;
  int        burst_left = 1;
  bus_item_t next_item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int next_slot(input int s);
    return (s + 1 >= QUEUE_DEPTH) ? 0 : s + 1;
  endfunction

  function automatic void reset_framing();
    q_header      = '0;
    q_pos         = 0;
    q_rejected    = 1'b0;
    q_reject_code = ST_READ;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_fill[i] = 0;
      q_bad[i]  = 1'b0;
    end
    q_wslot    = 0;
    q_rslot    = 0;
    q_waiting  = 0;
    q_roff     = 0;
    q_abnormal = 1'b0;
    reset_framing();
  endfunction

  // Drop the head entry and advance the read side.
  function automatic void retire_head();
    q_fill[q_rslot] = 0;
    q_bad[q_rslot]  = 1'b0;
    q_rslot         = next_slot(q_rslot);
    if (q_waiting > 0) q_waiting--;
    q_roff = 0;
  endfunction

  // Advance the shadow queue by one accepted item; queue the result it causes.
  task automatic predict_reassembly(input kind_t k, input logic [7:0] b, input logic tend,
                                    input logic terr);
    queue_result_t r;
    int            p;
    int            w;
    int            off;
    int            room;
    int            got;
    int            n;
    logic [15:0]   len;
    logic          produce;
    r.status     = ST_READ;
    r.read_byte  = 8'h00;
    r.entry_last = 1'b0;
    r.truncated  = 1'b0;
    produce      = 1'b1;
    case (k)
      KIND_RX: begin
        p = q_pos;
        w = q_wslot;
        if (p < HEADER_BYTES) begin
          q_header = {b, q_header[31:8]};
          // Decide the fate of the transfer on its last header byte.
          if (p == HEADER_BYTES - 1) begin
            q_rejected = 1'b1;
            if (q_header[15:0] != q_pipe_id) q_reject_code = ST_WRONG_ID;
            else if (q_waiting >= QUEUE_DEPTH) q_reject_code = ST_FULL;
            else if (q_abnormal) q_reject_code = ST_ABNORMAL;
            else q_rejected = 1'b0;
          end
        end else if (!q_rejected) begin
          off  = p - HEADER_BYTES;
          room = ENTRY_BYTES - q_fill[w];
          len  = q_header[31:16];
          if (off < len && off < room) q_store[w * ENTRY_BYTES + q_fill[w] + off] = b;
        end
        if (p < HEADER_BYTES + ENTRY_BYTES) p++;
        q_pos = p;
        if (!tend) begin
          produce = 1'b0;
        end else begin
          if (p < HEADER_BYTES) begin
            r.status = ST_SHORT;
          end else if (q_rejected) begin
            r.status = q_reject_code;
          end else if (terr) begin
            q_bad[w]   = 1'b1;
            q_wslot    = next_slot(w);
            q_waiting++;
            q_abnormal = 1'b1;
            r.status   = ST_ERROR;
          end else begin
            len  = q_header[31:16];
            room = ENTRY_BYTES - q_fill[w];
            got  = p - HEADER_BYTES;
            r.truncated = (len > room);
            n = len;
            if (n > room) n = room;
            if (n > got) n = got;
            q_fill[w] += n;
            if (n == 0 || n < CLOSE_BELOW) begin
              q_wslot = next_slot(w);
              q_waiting++;
              r.status = ST_CLOSED;
            end else begin
              r.status = ST_APPENDED;
            end
          end
          reset_framing();
        end
      end
      KIND_READ: begin
        if (q_waiting == 0) begin
          r.status = ST_EMPTY;
        end else if (q_bad[q_rslot] || q_fill[q_rslot] == 0) begin
          retire_head();
          r.status = ST_DROPPED;
        end else begin
          r.read_byte = q_store[q_rslot * ENTRY_BYTES + q_roff];
          q_roff++;
          if (q_roff >= q_fill[q_rslot]) begin
            r.entry_last = 1'b1;
            retire_head();
          end
          r.status = ST_READ;
        end
      end
      KIND_CLEAR: begin
        clear_model();
        r.status = ST_CLEARED;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
    if (produce) begin
      r.queue_count = 4'(q_waiting);
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH at result %0d: %s is %0d, expected %0d", results_checked, what, got,
               want);
  endtask

  // Monitor: sample at the rising edge, check results, then predict the item taken here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("pipe_packet_reassembly_queue test failed");
      $finish;
    end else begin
      item_taken = 1'b0;
      if (!rst_n) begin
        clear_model();
        q_pipe_id = 16'h0000;
      end else begin
        if (out_valid) begin
          results_checked++;
          status_seen[out_status] = 1'b1;
          if (expected_results.size() == 0) begin
            report_mismatch("status of unexpected result", out_status, -1);
          end else begin
            oldest = expected_results.pop_front();
            if (out_status !== oldest.status)
              report_mismatch("status", out_status, oldest.status);
            if (out_read_byte !== oldest.read_byte)
              report_mismatch("read_byte", out_read_byte, oldest.read_byte);
            if (out_entry_last !== oldest.entry_last)
              report_mismatch("entry_last", out_entry_last, oldest.entry_last);
            if (out_truncated !== oldest.truncated)
              report_mismatch("truncated", out_truncated, oldest.truncated);
            if (out_queue_count !== oldest.queue_count)
              report_mismatch("queue_count", out_queue_count, oldest.queue_count);
          end
        end
        if (cfg_we) q_pipe_id = cfg_pipe_id;
        if (start && !busy) begin
          item_taken = 1'b1;
          items_taken++;
          predict_reassembly(kind_t'(in_kind), in_rx_byte, in_transfer_end, in_rx_error);
        end
      end
    end
  end

  // Driver: change inputs at the falling edge, in bursts separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        start           <= 1'b1;
        in_kind         <= next_item.kind;
        in_rx_byte      <= next_item.data;
        in_transfer_end <= next_item.last;
        in_rx_error     <= next_item.err;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Pick the next burst: mostly short, sometimes a long stretch without gaps.
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_item(input kind_t k, input logic [7:0] b, input logic e, input logic er);
    bus_item_t it;
    it.kind = k;
    it.data = b;
    it.last = e;
    it.err  = er;
    pending_items.push_back(it);
    pushed++;
  endtask

  // Queue a whole transfer: header, then random payload; error only counts on the last byte.
  task automatic queue_transfer(input logic [15:0] id, input logic [15:0] len, input int payload,
                                input logic err);
    logic [31:0] header;
    int          total;
    logic        fin;
    header = {len, id};
    total  = HEADER_BYTES + payload;
    for (int i = 0; i < total; i++) begin
      fin = (i == total - 1);
      queue_item(KIND_RX, (i < HEADER_BYTES) ? header[8*i +: 8] : 8'($urandom), fin,
                 fin ? err : ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic queue_short(input int nbytes);
    for (int i = 0; i < nbytes; i++)
      queue_item(KIND_RX, 8'($urandom), i == nbytes - 1, $urandom_range(0, 1));
  endtask

  task automatic queue_reads(input int n);
    repeat (n) queue_item(KIND_READ, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // Wait until everything queued has been taken and answered, then let the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pipe_id(input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_pipe_id <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: mostly well-formed transfers and reads, with noise and broken framing.
  task automatic queue_random_traffic(input logic [15:0] pid, input int budget);
    int          goal;
    int          pick;
    int          pay;
    logic [15:0] len;
    logic [15:0] id;
    logic        err;
    goal = pushed + budget;
    while (pushed < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        pay = $urandom_range(0, 24);
        case ($urandom_range(0, 9))
          0:       len = 16'(pay + $urandom_range(1, 40));
          1:       len = 16'($urandom_range(0, pay));
          2:       len = 16'hFFFF;
          3:       len = 16'($urandom);
          default: len = 16'(pay);
        endcase
        err = ($urandom_range(0, 15) == 0);
        queue_transfer(pid, len, pay, err);
        // Recover from the abnormal state most of the time.
        if (err && $urandom_range(0, 3) != 0) begin
          queue_reads($urandom_range(1, 4));
          queue_item(KIND_CLEAR, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
        end
      end else if (pick < 55) begin
        queue_reads($urandom_range(1, 10));
      end else if (pick < 60) begin
        queue_item(KIND_CLEAR, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (pick < 68) begin
        id = pid ^ (16'h0001 << $urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) id = pid ^ 16'($urandom_range(1, 65535));
        queue_transfer(id, 16'($urandom_range(0, 8)), $urandom_range(0, 8), $urandom_range(0, 1));
      end else if (pick < 74) begin
        queue_short($urandom_range(1, HEADER_BYTES - 1));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6))
          queue_item(kind_t'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 1),
                     $urandom_range(0, 1));
        // Close whatever framing the noise left open.
        queue_item(KIND_RX, 8'($urandom), 1'b1, $urandom_range(0, 1));
      end else if (pick < 85) begin
        queue_item(KIND_NONE, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (pick < 89) begin
        // Abort a transfer by clear; the tail then frames as a new transfer.
        repeat ($urandom_range(1, 8)) queue_item(KIND_RX, 8'($urandom), 1'b0, $urandom_range(0, 1));
        queue_item(KIND_CLEAR, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) queue_short($urandom_range(1, 6));
      end else begin
        queue_reads($urandom_range(10, 30));
      end
    end
  endtask

  initial begin
    int          seen;
    logic [15:0] phase_id;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty read, short, small transfer with extreme bytes, zero-length close,
    // wrong id, read-out with empty-entry drop, unused kind, clear mid-transfer.
    write_pipe_id(16'h0000);
    queue_reads(1);
    queue_short(2);
    queue_item(KIND_RX, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_RX, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_RX, 8'h03, 1'b0, 1'b0);
    queue_item(KIND_RX, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_RX, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_RX, 8'hFF, 1'b0, 1'b1);
    queue_item(KIND_RX, 8'h5A, 1'b1, 1'b0);
    queue_transfer(16'h0000, 16'h0000, 0, 1'b0);
    queue_transfer(16'hFFFF, 16'h0000, 0, 1'b0);
    queue_reads(4);
    queue_item(KIND_NONE, 8'hA5, 1'b1, 1'b1);
    queue_item(KIND_RX, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_RX, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_CLEAR, 8'hFF, 1'b1, 1'b1);

    // Corners: error marks the entry bad and blocks later transfers until clear.
    write_pipe_id(16'hFFFF);
    queue_transfer(16'hFFFF, 16'd5, 5, 1'b0);
    queue_transfer(16'hFFFF, 16'd20, 7, 1'b1);
    queue_transfer(16'hFFFF, 16'd4, 4, 1'b0);
    queue_transfer(16'h7FFF, 16'd4, 4, 1'b0);
    queue_short(3);
    queue_reads(8);
    queue_item(KIND_CLEAR, 8'h00, 1'b0, 1'b0);
    // Fill every slot, then hit the full check with and without error status.
    for (int i = 0; i < QUEUE_DEPTH; i++) queue_transfer(16'hFFFF, 16'(i + 1), i % 4, 1'b0);
    queue_transfer(16'hFFFF, 16'd2, 2, 1'b0);
    queue_transfer(16'hFFFF, 16'd2, 2, 1'b1);
    queue_reads(QUEUE_DEPTH * 4 + 2);
    // Append a full-size packet with an overlong length, close the entry with a
    // zero-length packet, read its first bytes and drop the rest by clear.
    queue_transfer(16'hFFFF, 16'hFFFF, CLOSE_BELOW, 1'b0);
    queue_transfer(16'hFFFF, 16'h0000, 0, 1'b0);
    queue_reads(3);
    queue_item(KIND_CLEAR, 8'h00, 1'b0, 1'b0);

    // Random traffic under two more pipe ids, pausing for a full drain in between.
    phase_id = 16'($urandom);
    write_pipe_id(phase_id);
    queue_random_traffic(phase_id, RANDOM_ITEMS / 4);
    wait_drained();
    queue_random_traffic(phase_id, RANDOM_ITEMS / 4);
    phase_id = 16'($urandom);
    write_pipe_id(phase_id);
    queue_random_traffic(phase_id, RANDOM_ITEMS / 2);

    wait_drained();
    seen = 0;
    foreach (status_seen[i]) if (status_seen[i] === 1'b1) seen++;
    $display("Run covered %0d items and %0d results across four pipe id settings",
             items_taken, results_checked);
    $display("Distinct result status codes observed: %0d of %0d", seen, int'(ST_CLEARED) + 1);
    if (mismatches == 0) begin
      $display("pipe_packet_reassembly_queue test passed");
    end else begin
      $display("pipe_packet_reassembly_queue test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ppr_pkg.sv
src/ppr_ram.sv
src/pipe_packet_reassembly_queue.sv
bench/pipe_packet_reassembly_queue_tb.sv
